FILE: rtl/crcbr_pkg.sv
// Package: shared types, constants and CRC step function for the CRC-16 frame reassembler.
package crcbr_pkg;

    localparam int P_FRAME_BYTES  = 64;
    localparam int P_HEADER_BYTES = 1;

    localparam int CAP_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int COUNT_W = 16;

    localparam logic [CRC_W-1:0] CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;
    localparam logic [CAP_W-1:0] CAP_RESET = 12'd4000;

    typedef enum logic [2:0] {
        S_RECV,
        S_CALC,
        S_UPD,
        S_STATUS,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic rx_take;
        logic calc;
        logic update;
        logic rd;
        logic load_byte;
        logic load_status;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
        logic copy_zero;
        logic idx_last;
        logic out_free;
    } t_dp_sts;

    // reflected CRC-16/Modbus over one byte, low bit first
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crcbr_ctrl.sv
// Controller: state machine sequencing reception, frame check and result emission.
module crcbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  crcbr_pkg::t_dp_sts i_sts,
    output crcbr_pkg::t_dp_cmd o_cmd
);
    import crcbr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RECV: begin
                if (i_valid && i_sts.frame_end) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = i_sts.copy_zero ? S_STATUS : S_EMIT_RD;
            end
            S_STATUS: begin
                if (i_sts.out_free) begin
                    n_state = S_RECV;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.idx_last ? S_RECV : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_RECV: begin
                o_stall       = 1'b0;
                o_cmd.rx_take = i_valid;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
            end
            S_STATUS: begin
                o_cmd.load_status = i_sts.out_free;
            end
            S_EMIT_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_EMIT_OUT: begin
                o_cmd.load_byte = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/crcbr_dp.sv
// Datapath: frame store, CRC, counters, trim arithmetic and output register.
module crcbr_dp #(
    parameter int FRAME_BYTES  = crcbr_pkg::P_FRAME_BYTES,
    parameter int HEADER_BYTES = crcbr_pkg::P_HEADER_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  crcbr_pkg::t_dp_cmd              i_cmd,
    output crcbr_pkg::t_dp_sts              o_sts,
    input  logic [crcbr_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                            i_cfg_we,
    input  logic [crcbr_pkg::CAP_W-1:0]     i_cfg_data,
    input  logic                            i_stall,
    output logic                            o_valid,
    output logic [crcbr_pkg::CAP_W-1:0]     o_store_offset,
    output logic [crcbr_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                            o_byte_valid,
    output logic                            o_crc_ok,
    output logic [crcbr_pkg::COUNT_W-1:0]   o_corrupted_count,
    output logic [crcbr_pkg::CAP_W-1:0]     o_total_received,
    output logic                            o_receive_done,
    output logic                            o_last
);
    import crcbr_pkg::*;

    localparam int IDX_W   = $clog2(FRAME_BYTES);
    localparam int PAYLOAD = (FRAME_BYTES > HEADER_BYTES + 2) ?
                             (FRAME_BYTES - HEADER_BYTES - 2) : 0;
    localparam logic [IDX_W-1:0] POS_HI   = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] POS_END  = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] HDR_OFS  = IDX_W'(HEADER_BYTES);
    localparam logic [CAP_W-1:0] PAYLOAD_C = CAP_W'(PAYLOAD);

    logic [BYTE_W-1:0]  r_mem [FRAME_BYTES];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [IDX_W-1:0]   r_pos;
    logic [CRC_W-1:0]   r_crc;
    logic [BYTE_W-1:0]  r_crc_hi;
    logic               r_crc_ok;
    logic [COUNT_W-1:0] r_corrupt;
    logic [CAP_W-1:0]   r_stored;
    logic [CAP_W-1:0]   r_cap;
    logic [CAP_W-1:0]   r_base;
    logic [IDX_W-1:0]   r_copy;
    logic [IDX_W-1:0]   r_idx;
    logic               r_o_valid;

    logic [CAP_W-1:0]   n_avail;
    logic [IDX_W-1:0]   n_copy;
    logic               n_match;
    logic [IDX_W:0]     n_idx_inc;

    assign n_avail   = r_cap - r_stored;
    assign n_match   = ({r_crc_hi, i_rx_byte} == r_crc);
    assign n_idx_inc = {1'b0, r_idx} + {{IDX_W{1'b0}}, 1'b1};

    always_comb begin
        if (!r_crc_ok || (r_stored >= r_cap)) begin
            n_copy = '0;
        end else if (n_avail > PAYLOAD_C) begin
            n_copy = PAYLOAD_C[IDX_W-1:0];
        end else begin
            n_copy = n_avail[IDX_W-1:0];
        end
    end

    assign o_sts.frame_end = (r_pos == POS_END);
    assign o_sts.copy_zero = (r_copy == '0);
    assign o_sts.idx_last  = (n_idx_inc == {1'b0, r_copy});
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    // frame store
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_take && (r_pos < POS_HI)) begin
            r_mem[r_pos] <= i_rx_byte;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[HDR_OFS + r_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_crc     <= CRC_INIT;
            r_corrupt <= '0;
            r_stored  <= '0;
            r_cap     <= CAP_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.rx_take) begin
                if (r_pos < POS_HI) begin
                    r_crc <= crc16_byte(r_crc, i_rx_byte);
                    r_pos <= r_pos + 1'b1;
                end else if (r_pos == POS_HI) begin
                    r_pos <= r_pos + 1'b1;
                end else begin
                    r_pos <= '0;
                    r_crc <= CRC_INIT;
                    if (!n_match) begin
                        r_corrupt <= r_corrupt + 1'b1;
                    end
                end
            end
            if (i_cmd.update) begin
                r_stored <= r_stored + CAP_W'(r_copy);
            end
            if (i_cmd.load_byte || i_cmd.load_status) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_take && (r_pos == POS_HI)) begin
            r_crc_hi <= i_rx_byte;
        end
        if (i_cmd.rx_take && (r_pos == POS_END)) begin
            r_crc_ok <= n_match;
        end
        if (i_cmd.calc) begin
            r_copy <= n_copy;
        end
        if (i_cmd.update) begin
            r_base <= r_stored;
            r_idx  <= '0;
        end
        if (i_cmd.load_byte) begin
            o_store_offset <= r_base + CAP_W'(r_idx);
            o_payload_byte <= r_rd_data;
            o_byte_valid   <= 1'b1;
            o_crc_ok       <= 1'b1;
            o_last         <= o_sts.idx_last;
            r_idx          <= n_idx_inc[IDX_W-1:0];
        end else if (i_cmd.load_status) begin
            o_store_offset <= '0;
            o_payload_byte <= '0;
            o_byte_valid   <= 1'b0;
            o_crc_ok       <= r_crc_ok;
            o_last         <= 1'b1;
        end
        if (i_cmd.load_byte || i_cmd.load_status) begin
            o_corrupted_count <= r_corrupt;
            o_total_received  <= r_stored;
            o_receive_done    <= (r_stored >= r_cap);
        end
    end

    assign o_valid = r_o_valid;

endmodule

FILE: rtl/crc16_checked_block_reassembler.sv
// Top level: CRC-16/Modbus checked frame reassembler.
//
//   channel   direction  handshake            word
//   rx        in         i_valid / o_stall    i_rx_byte
//   result    out        o_valid / i_stall    store offset, payload byte, frame status
//   config    in         i_cfg_we             i_cfg_data (capacity in bytes)
//
// Non-final bytes of a frame are taken without stall. After the frame-end byte come
// the trim calculation and stored-total update, then per emitted payload word a frame
// store read then an output register load, or a single output load for a status word.
// No input is taken from frame end until the last result word is loaded.
// Reset is synchronous; the frame store needs no clearing.
module crc16_checked_block_reassembler #(
    parameter int FRAME_BYTES  = crcbr_pkg::P_FRAME_BYTES,
    parameter int HEADER_BYTES = crcbr_pkg::P_HEADER_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [crcbr_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                            i_cfg_we,
    input  logic [crcbr_pkg::CAP_W-1:0]     i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [crcbr_pkg::CAP_W-1:0]     o_store_offset,
    output logic [crcbr_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic                            o_byte_valid,
    output logic                            o_crc_ok,
    output logic [crcbr_pkg::COUNT_W-1:0]   o_corrupted_count,
    output logic [crcbr_pkg::CAP_W-1:0]     o_total_received,
    output logic                            o_receive_done,
    output logic                            o_last
);
    import crcbr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    crcbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    crcbr_dp #(
        .FRAME_BYTES  (FRAME_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_store_offset    (o_store_offset),
        .o_payload_byte    (o_payload_byte),
        .o_byte_valid      (o_byte_valid),
        .o_crc_ok          (o_crc_ok),
        .o_corrupted_count (o_corrupted_count),
        .o_total_received  (o_total_received),
        .o_receive_done    (o_receive_done),
        .o_last            (o_last)
    );

`ifndef SYNTH
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> o_last)
        else $error("status word without last");

    a_bad_crc_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_crc_ok) |-> !o_byte_valid)
        else $error("data word from failed frame");

    a_offset_in_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_valid) |-> (o_store_offset < o_total_received))
        else $error("store offset beyond stored total");

    a_no_rx_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_stall)
        else $error("input taken while frame words pending");
`endif

endmodule

FILE: dv/tb.sv
// Testbench for the CRC-16 checked frame reassembler: frames in, checked payload and status out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crcbr_pkg::*;

    localparam int PAYLOAD     = P_FRAME_BYTES - P_HEADER_BYTES - 2;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;

    typedef enum {FILL_ALT, FILL_RAMP, FILL_RAND} t_fill;
    typedef enum {CRC_GOOD, CRC_FLIP, CRC_NOISE} t_crc_mode;

    typedef struct {
        logic [CAP_W-1:0]   offset;
        logic [BYTE_W-1:0]  data;
        logic               valid_byte;
        logic               crc_ok;
        logic [COUNT_W-1:0] bad_count;
        logic [CAP_W-1:0]   total;
        logic               done;
        logic               last_word;
    } t_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_rx_byte;
    logic                i_cfg_we;
    logic [CAP_W-1:0]    i_cfg_data;
    logic                o_valid;
    logic                i_stall;
    logic [CAP_W-1:0]    o_store_offset;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic                o_byte_valid;
    logic                o_crc_ok;
    logic [COUNT_W-1:0]  o_corrupted_count;
    logic [CAP_W-1:0]    o_total_received;
    logic                o_receive_done;
    logic                o_last;

    // frame checker state as the block should hold it
    logic [BYTE_W-1:0]   frame_buf [P_FRAME_BYTES];
    int                  rx_pos = 0;
    logic [CRC_W-1:0]    run_crc = CRC_INIT;
    logic [BYTE_W-1:0]   crc_hi = '0;
    int                  bad_frames = 0;
    int                  stored = 0;
    int                  capacity = CAP_RESET;
    t_word               expected_words [$];
    t_word               front;

    int                  errors = 0;
    int                  cycles = 0;
    bit                  idling = 0;
    int                  hold_left = 0;
    int                  stall_left = 0;

    crc16_checked_block_reassembler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_store_offset    (o_store_offset),
        .o_payload_byte    (o_payload_byte),
        .o_byte_valid      (o_byte_valid),
        .o_crc_ok          (o_crc_ok),
        .o_corrupted_count (o_corrupted_count),
        .o_total_received  (o_total_received),
        .o_receive_done    (o_receive_done),
        .o_last            (o_last)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (!idling) begin
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
    endfunction

    function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             lsb;
        c = crc ^ CRC_W'(b);
        repeat (8) begin
            lsb = c[0];
            c = c >> 1;
            if (lsb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic t_word make_word(input int offset, input logic [BYTE_W-1:0] data,
                                        input bit valid_byte, input bit ok, input bit last_word);
        t_word w;
        w.offset     = CAP_W'(offset);
        w.data       = data;
        w.valid_byte = valid_byte;
        w.crc_ok     = ok;
        w.bad_count  = COUNT_W'(bad_frames);
        w.total      = CAP_W'(stored);
        w.done       = (stored >= capacity);
        w.last_word  = last_word;
        return w;
    endfunction

    task automatic predict_rx(input logic [BYTE_W-1:0] b);
        int copy;
        int base;
        if (rx_pos < P_FRAME_BYTES - 2) begin
            frame_buf[rx_pos] = b;
            run_crc = crc_next(run_crc, b);
            rx_pos++;
        end else if (rx_pos == P_FRAME_BYTES - 2) begin
            crc_hi = b;
            rx_pos++;
        end else begin
            rx_pos = 0;
            if ({crc_hi, b} != run_crc) begin
                run_crc = CRC_INIT;
                bad_frames = (bad_frames + 1) & 16'hFFFF;
                expected_words.push_back(make_word(0, 8'h00, 1'b0, 1'b0, 1'b1));
            end else begin
                run_crc = CRC_INIT;
                if (stored >= capacity) begin
                    copy = 0;
                end else if (stored + PAYLOAD > capacity) begin
                    copy = capacity - stored;
                end else begin
                    copy = PAYLOAD;
                end
                base = stored;
                stored = stored + copy;
                if (copy == 0) begin
                    expected_words.push_back(make_word(0, 8'h00, 1'b0, 1'b1, 1'b1));
                end
                for (int i = 0; i < copy; i++) begin
                    expected_words.push_back(make_word(base + i,
                                                       frame_buf[P_HEADER_BYTES + i],
                                                       1'b1, 1'b1, i + 1 == copy));
                end
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing pending: offset %0h byte %0h",
                       o_store_offset, o_payload_byte);
                errors++;
            end else begin
                front = expected_words.pop_front();
                check_field("store_offset", front.offset, o_store_offset);
                check_field("payload_byte", front.data, o_payload_byte);
                check_field("byte_valid", front.valid_byte, o_byte_valid);
                check_field("crc_ok", front.crc_ok, o_crc_ok);
                check_field("corrupted_count", front.bad_count, o_corrupted_count);
                check_field("total_received", front.total, o_total_received);
                check_field("receive_done", front.done, o_receive_done);
                check_field("last", front.last_word, o_last);
            end
            stall_left = draw_gap();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: long hold first, then the per-word stall
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // returns at the accepting rising edge with valid still high
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall);
        predict_rx(b);
    endtask

    task automatic release_rx();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_frame(input t_fill fill, input t_crc_mode mode);
        logic [BYTE_W-1:0] fr [P_FRAME_BYTES];
        logic [CRC_W-1:0]  crc;
        int                idx;
        crc = CRC_INIT;
        for (int i = 0; i < P_FRAME_BYTES - 2; i++) begin
            case (fill)
                FILL_ALT:  fr[i] = i[0] ? 8'hFF : 8'h00;
                FILL_RAMP: fr[i] = 8'(i * 37 + 1);
                default:   fr[i] = 8'($urandom);
            endcase
            crc = crc_next(crc, fr[i]);
        end
        fr[P_FRAME_BYTES-2] = crc[15:8];
        fr[P_FRAME_BYTES-1] = crc[7:0];
        if (mode == CRC_FLIP) begin
            idx = $urandom_range(0, P_FRAME_BYTES - 1);
            fr[idx] = fr[idx] ^ 8'(1 << $urandom_range(0, 7));
        end else if (mode == CRC_NOISE) begin
            fr[P_FRAME_BYTES-2] = 8'($urandom);
            fr[P_FRAME_BYTES-1] = 8'($urandom);
        end
        foreach (fr[i]) begin
            send_byte(fr[i]);
        end
    endtask

    task automatic write_capacity(input int value);
        release_rx();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = CAP_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        capacity = value & 12'hFFF;
    endtask

    task automatic test_clean_frame();
        idling = 0;
        send_frame(FILL_ALT, CRC_GOOD);
    endtask

    task automatic test_crc_errors();
        send_frame(FILL_RAMP, CRC_FLIP);
    endtask

    task automatic test_capacity_trim();
        write_capacity(stored + 5);
        idling = 1;
        send_frame(FILL_RAMP, CRC_GOOD);
        write_capacity(0);
        send_frame(FILL_RAND, CRC_GOOD);
    endtask

    task automatic test_backpressure();
        write_capacity(4095);
        idling = 1;
        send_frame(FILL_RAND, CRC_GOOD);
        hold_left = 400;
        send_frame(FILL_RAND, CRC_GOOD);
    endtask

    task automatic test_random_traffic();
        int next_cap;
        int pick;
        repeat (1) begin
            next_cap = -1;
            case ($urandom_range(0, 5))
                0: next_cap = 4095;
                1: next_cap = stored + $urandom_range(1, 60);
                2: next_cap = stored;
                3: next_cap = $urandom_range(0, 4095);
                default: next_cap = -1;
            endcase
            if (next_cap > 4095) begin
                next_cap = 4095;
            end
            if (next_cap >= 0) begin
                write_capacity(next_cap);
            end
            idling = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(FILL_RAND, CRC_GOOD);
            end else if (pick < 9) begin
                send_frame(FILL_RAND, CRC_FLIP);
            end else begin
                send_frame(FILL_RAND, CRC_NOISE);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_rx_byte = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_clean_frame();
        test_crc_errors();
        test_capacity_trim();
        test_backpressure();
        test_random_traffic();

        release_rx();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
